// ===== rtl/core/drtu_pkg.sv =====
// ----------------------------------------------------------------------------
// drtu_pkg
// Shared types and constants of the duration round and truncate unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package drtu_pkg;

   localparam int unsigned DataWidth = 64;
   localparam int unsigned CellCount = DataWidth;

   localparam logic [2:0] OP_TRUNCATE = 3'd0;
   localparam logic [2:0] OP_ROUND    = 3'd1;
   localparam logic [2:0] OP_ABS      = 3'd2;
   localparam logic [2:0] OP_TO_US    = 3'd3;
   localparam logic [2:0] OP_TO_MS    = 3'd4;

   localparam logic [DataWidth-1:0] US_DIVISOR = 64'd1000;
   localparam logic [DataWidth-1:0] MS_DIVISOR = 64'd1000000;
   localparam logic [DataWidth-1:0] I64_MAX    = {1'b0, {(DataWidth-1){1'b1}}};
   localparam logic [DataWidth-1:0] I64_MIN    = {1'b1, {(DataWidth-1){1'b0}}};

   typedef enum logic [2:0] {
      KIND_PASS  = 3'd0,
      KIND_TRUNC = 3'd1,
      KIND_ROUND = 3'd2,
      KIND_ABS   = 3'd3,
      KIND_CONV  = 3'd4
   } drtu_kind_type;

   typedef struct packed {
      drtu_kind_type        kind;
      logic                 neg;
      logic [DataWidth-1:0] value;
      logic [DataWidth-1:0] multiple;
      logic [DataWidth-1:0] divisor;
      logic [DataWidth-1:0] rem;
      logic [DataWidth-1:0] aq;
   } drtu_stage_type;

endpackage
`default_nettype wire

// ===== rtl/core/drtu_pre.sv =====
// ----------------------------------------------------------------------------
// drtu_pre
// Entry stage: decodes the operation, takes magnitudes, picks the divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module drtu_pre import drtu_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic [2:0]           in_operation,
   input  wire logic [DataWidth-1:0] in_value,
   input  wire logic [DataWidth-1:0] in_multiple,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output drtu_stage_type            out_data
);

   logic           valid_ff;
   drtu_stage_type data_ff, data_in;
   logic           neg;
   logic           mult_pos;
   logic [DataWidth-1:0] mag;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      neg      = in_value[DataWidth-1];
      mag      = neg ? (~in_value + 1'b1) : in_value;
      mult_pos = !in_multiple[DataWidth-1] && (in_multiple != '0);
      data_in          = '0;
      data_in.kind     = KIND_PASS;
      data_in.neg      = neg;
      data_in.value    = in_value;
      data_in.multiple = in_multiple;
      data_in.divisor  = {{(DataWidth-1){1'b0}}, 1'b1};
      data_in.aq       = mag;
      case (in_operation)
         OP_TRUNCATE: begin
            if (mult_pos) begin
               data_in.kind    = KIND_TRUNC;
               data_in.divisor = in_multiple;
            end
         end
         OP_ROUND: begin
            if (mult_pos) begin
               data_in.kind    = KIND_ROUND;
               data_in.divisor = in_multiple;
            end
         end
         OP_ABS: begin
            data_in.kind     = KIND_ABS;
            data_in.multiple = (in_value == I64_MIN) ? I64_MAX : mag;
         end
         OP_TO_US: begin
            data_in.kind    = KIND_CONV;
            data_in.divisor = US_DIVISOR;
         end
         OP_TO_MS: begin
            data_in.kind    = KIND_CONV;
            data_in.divisor = MS_DIVISOR;
         end
         default: data_in.kind = KIND_PASS;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/drtu_cell.sv =====
// ----------------------------------------------------------------------------
// drtu_cell
// One restoring division step: yields one quotient bit per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module drtu_cell import drtu_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  drtu_stage_type in_data,
   output logic          out_valid,
   input  wire logic     out_ready,
   output drtu_stage_type out_data
);

   logic           valid_ff;
   drtu_stage_type data_ff, data_in;
   logic [DataWidth:0] shifted;
   logic [DataWidth:0] diff;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      shifted = {in_data.rem, in_data.aq[DataWidth-1]};
      diff    = shifted - {1'b0, in_data.divisor};
      data_in = in_data;
      if (!diff[DataWidth]) begin
         data_in.rem = diff[DataWidth-1:0];
         data_in.aq  = {in_data.aq[DataWidth-2:0], 1'b1};
      end else begin
         data_in.rem = shifted[DataWidth-1:0];
         data_in.aq  = {in_data.aq[DataWidth-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/drtu_post.sv =====
// ----------------------------------------------------------------------------
// drtu_post
// Exit stage: forms the rounded, truncated, absolute or converted result, or passes the value through.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module drtu_post import drtu_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  drtu_stage_type            in_data,
   output logic                      out_valid,
   input  wire logic                 out_stall,
   output logic [DataWidth-1:0]      out_result,
   output logic                      out_saturated
);

   logic                 valid_ff;
   logic [DataWidth-1:0] result_ff, result_in;
   logic                 sat_ff, sat_in;
   logic [DataWidth-1:0] near;
   logic [DataWidth-1:0] gap;
   logic [DataWidth+1:0] far;
   logic                 half_below;
   logic                 far_ovf;

   assign in_ready      = !valid_ff || !out_stall;
   assign out_valid     = valid_ff;
   assign out_result    = result_ff;
   assign out_saturated = sat_ff;

   always_comb begin
      near       = in_data.neg ? (in_data.value + in_data.rem)
                               : (in_data.value - in_data.rem);
      half_below = {in_data.rem, 1'b0} < {1'b0, in_data.multiple};
      gap        = in_data.multiple - in_data.rem;
      far        = in_data.neg
                   ? ({{2{in_data.value[DataWidth-1]}}, in_data.value} - {2'b00, gap})
                   : ({{2{in_data.value[DataWidth-1]}}, in_data.value} + {2'b00, gap});
      far_ovf    = !((far[DataWidth+1:DataWidth-1] == 3'b000)
                     || (far[DataWidth+1:DataWidth-1] == 3'b111));
      result_in  = in_data.value;
      sat_in     = 1'b0;
      case (in_data.kind)
         KIND_TRUNC: result_in = near;
         KIND_ROUND: begin
            if (half_below) begin
               result_in = near;
            end else if (far_ovf) begin
               result_in = in_data.neg ? I64_MIN : I64_MAX;
               sat_in    = 1'b1;
            end else begin
               result_in = far[DataWidth-1:0];
            end
         end
         KIND_ABS: begin
            result_in = in_data.multiple;
            sat_in    = (in_data.value == I64_MIN);
         end
         KIND_CONV: result_in = in_data.neg ? (~in_data.aq + 1'b1) : in_data.aq;
         default:   result_in = in_data.value;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         result_ff <= result_in;
         sat_ff    <= sat_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/duration_round_truncate_unit_core.sv =====
// ----------------------------------------------------------------------------
// duration_round_truncate_unit_core
// Signed 64-bit duration truncate, round, absolute value and unit conversion.
//
// Items enter on req_ (operation, value, multiple) and leave on rsp_
// (result, saturated), one result per item, in order.
// The pipeline is one decode stage, a chain of 64 division cells
// (one quotient bit each) and one result stage.
// Throughput is one item per cycle while rsp_stall is low; the chain is fully pipelined.
// Every stage holds its item while the next one is full and cannot pass on, so bubbles close
// up and a new item is taken while a result waits on rsp_stall, as long as some stage is empty.
// req_stall rises only when every stage is full and rsp_stall is high.
// Reset clears all stage valid flags; rsp_valid is low after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module duration_round_truncate_unit_core import drtu_pkg::*; (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [2:0]                  req_operation,
   input  wire logic signed [DataWidth-1:0] req_value,
   input  wire logic signed [DataWidth-1:0] req_multiple,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic signed [DataWidth-1:0]      rsp_result,
   output logic                             rsp_saturated
);

   logic           req_ready;
   logic           chain_valid [CellCount+1];
   logic           chain_ready [CellCount+1];
   drtu_stage_type chain_data  [CellCount+1];
   logic [DataWidth-1:0] result;

   assign req_stall  = !req_ready;
   assign rsp_result = $signed(result);

   drtu_pre u_pre (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .in_operation (req_operation),
      .in_value     (req_value),
      .in_multiple  (req_multiple),
      .out_valid    (chain_valid[0]),
      .out_ready    (chain_ready[0]),
      .out_data     (chain_data[0])
   );

   for (genvar i = 0; i < CellCount; i++) begin : g_cell
      drtu_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   drtu_post u_post (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (chain_valid[CellCount]),
      .in_ready      (chain_ready[CellCount]),
      .in_data       (chain_data[CellCount]),
      .out_valid     (rsp_valid),
      .out_stall     (rsp_stall),
      .out_result    (result),
      .out_saturated (rsp_saturated)
   );

endmodule
`default_nettype wire

// ===== rtl/core/drtu_checker.sv =====
// ----------------------------------------------------------------------------
// drtu_checker
// Port-level checks of the duration round and truncate unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module drtu_checker import drtu_pkg::*; (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_stall,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire logic [DataWidth-1:0] rsp_result,
   input wire logic                 rsp_saturated
);

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while output free");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |-> (rsp_result == I64_MAX || rsp_result == I64_MIN))
      else $error("saturated result not at a limit");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled result dropped");

endmodule

bind duration_round_truncate_unit_core drtu_checker u_drtu_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_result    (rsp_result),
   .rsp_saturated (rsp_saturated)
);
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the duration round and truncate unit.
// A queue of items feeds a clocked driver; a monitor compares every result
// against a behavioural predictor of truncate, round, abs and conversions.
// ----------------------------------------------------------------------------
module tb;
   import drtu_pkg::*;

   typedef struct {
      logic [2:0]  op;
      logic [63:0] val;
      logic [63:0] mul;
   } dur_item_t;

   typedef struct {
      logic [63:0] res;
      logic        sat;
   } dur_rsp_t;

   localparam int WatchLimit = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_operation = '0;
   logic signed [63:0] req_value = '0;
   logic signed [63:0] req_multiple = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [63:0] rsp_result;
   logic rsp_saturated;

   dur_item_t pending_items[$];
   dur_rsp_t  expected_rsps[$];
   int  error_count = 0;
   int  idle_cycles = 0;
   int  send_gap = 0;
   int  stall_left = 0;
   bit  quiet = 1'b0;
   bit  hold_send = 1'b0;
   bit  stim_done = 1'b0;
   bit  req_taken = 1'b0;

   duration_round_truncate_unit_core u_dut (.*);

   always #5 clock = ~clock;

   function automatic dur_rsp_t predict_duration(dur_item_t it);
      dur_rsp_t o;
      longint d;
      longint m;
      longint r;
      longint cand;
      d = it.val;
      m = it.mul;
      o.res = it.val;
      o.sat = 1'b0;
      case (it.op)
         OP_TRUNCATE: begin
            if (m > 0) o.res = d - d % m;
         end
         OP_ROUND: begin
            if (m > 0) begin
               r = d % m;
               if (d < 0) begin
                  r = -r;
                  if ((unsigned'(r) << 1) < unsigned'(m)) o.res = d + r;
                  else begin
                     cand = longint'(64'(d) - 64'(m) + 64'(r));
                     if (cand < d) o.res = cand;
                     else begin
                        o.res = I64_MIN;
                        o.sat = 1'b1;
                     end
                  end
               end else begin
                  if ((unsigned'(r) << 1) < unsigned'(m)) o.res = d - r;
                  else begin
                     cand = longint'(64'(d) + 64'(m) - 64'(r));
                     if (cand > d) o.res = cand;
                     else begin
                        o.res = I64_MAX;
                        o.sat = 1'b1;
                     end
                  end
               end
            end
         end
         OP_ABS: begin
            if (it.val == I64_MIN) begin
               o.res = I64_MAX;
               o.sat = 1'b1;
            end else o.res = (d < 0) ? -d : d;
         end
         OP_TO_US: o.res = d / 1000;
         OP_TO_MS: o.res = d / 1000000;
         default: ;
      endcase
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      error_count++;
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
   endtask

   task automatic push_item(logic [2:0] op, logic [63:0] v, logic [63:0] m);
      dur_item_t it;
      it.op = op;
      it.val = v;
      it.mul = m;
      pending_items.push_back(it);
   endtask

   function automatic logic [63:0] rand_word();
      logic [63:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: w = $signed(w[15:0]);
         1: w = $signed(w[31:0]);
         2: w = {w[63], {63{~w[63]}}} ^ {1'b0, 63'($urandom_range(0, 3))};
         default: ;
      endcase
      return w;
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && req_taken) begin
            if (!hold_send && send_gap == 0 && pending_items.size() > 0) begin
               req_operation <= pending_items[0].op;
               req_value <= pending_items[0].val;
               req_multiple <= pending_items[0].mul;
               expected_rsps.push_back(predict_duration(pending_items[0]));
               void'(pending_items.pop_front());
            end else req_valid <= 1'b0;
         end else if (!req_valid) begin
            if (!hold_send && send_gap == 0 && pending_items.size() > 0) begin
               req_valid <= 1'b1;
               req_operation <= pending_items[0].op;
               req_value <= pending_items[0].val;
               req_multiple <= pending_items[0].mul;
               expected_rsps.push_back(predict_duration(pending_items[0]));
               void'(pending_items.pop_front());
            end
         end
         if (send_gap > 0) send_gap <= send_gap - 1;
         else if (!quiet && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 7);
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            stall_left <= $urandom_range(0, 6);
         end else rsp_stall <= 1'b0;
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         req_taken <= req_valid && !req_stall;
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > WatchLimit) begin
            $display("duration_round_truncate_unit_core verification failed");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) report_mismatch("unexpected item", rsp_result, '0);
            else begin
               if (rsp_result !== expected_rsps[0].res)
                  report_mismatch("result", rsp_result, expected_rsps[0].res);
               if (rsp_saturated !== expected_rsps[0].sat)
                  report_mismatch("saturated", 64'(rsp_saturated), 64'(expected_rsps[0].sat));
               void'(expected_rsps.pop_front());
            end
         end
      end
   end

   initial begin
      push_item(OP_TRUNCATE, 64'sd1234567, 64'sd1000);
      push_item(OP_TRUNCATE, -64'sd1234567, 64'sd1000);
      push_item(OP_TRUNCATE, 64'sd1234567, 64'sd0);
      push_item(OP_TRUNCATE, 64'sd1234567, -64'sd5);
      push_item(OP_TRUNCATE, I64_MIN, I64_MAX);
      push_item(OP_ROUND, 64'sd1500, 64'sd1000);
      push_item(OP_ROUND, -64'sd1500, 64'sd1000);
      push_item(OP_ROUND, 64'sd1499, 64'sd1000);
      push_item(OP_ROUND, 64'sd77, I64_MIN);
      push_item(OP_ROUND, 64'sd77, 64'sd0);
      push_item(OP_ROUND, I64_MAX, 64'sd1000);
      push_item(OP_ROUND, I64_MIN, 64'sd1000);
      push_item(OP_ROUND, I64_MAX, I64_MAX);
      push_item(OP_ROUND, I64_MIN + 64'd1, I64_MAX);
      push_item(OP_ABS, I64_MIN, 64'sd0);
      push_item(OP_ABS, -64'sd42, 64'sd0);
      push_item(OP_ABS, I64_MAX, 64'sd0);
      push_item(OP_TO_US, -64'sd999, 64'sd0);
      push_item(OP_TO_US, I64_MIN, 64'sd0);
      push_item(OP_TO_MS, I64_MAX, 64'sd0);
      push_item(OP_TO_MS, -64'sd2000001, 64'sd0);
      push_item(3'd5, 64'sd9, 64'sd1);
      push_item(3'd6, -64'sd9, 64'sd1);
      push_item(3'd7, I64_MIN, I64_MAX);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 650; i++) begin
         logic [63:0] m;
         m = rand_word();
         if ($urandom_range(0, 3) != 0) m = 64'($urandom_range(1, 1 << $urandom_range(1, 30)));
         push_item(($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4)), rand_word(), m);
         if (i == 300) begin
            wait (pending_items.size() == 0);
            @(negedge clock);
            hold_send = 1'b1;
            wait (expected_rsps.size() == 0);
            @(negedge clock);
            hold_send = 1'b0;
         end
         if (i == 550) begin
            wait (pending_items.size() == 0);
            quiet = 1'b1;
         end
      end
      wait (pending_items.size() == 0 && !req_valid);
      wait (expected_rsps.size() == 0);
      repeat (80) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0)
         $display("duration_round_truncate_unit_core verification clean");
      else
         $display("duration_round_truncate_unit_core verification failed");
      $finish;
   end

endmodule
